// ===== rtl/core/typed_message_queue_core_assert.svh =====
// Assertion macros for the checker file of the typed message queue.
`ifndef TYPED_MESSAGE_QUEUE_CORE_ASSERT_SVH
`define TYPED_MESSAGE_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define TMQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define TMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tmq_pkg.sv =====
// Types, codes and helper functions of the typed message queue.
package tmq_pkg;

	localparam int TMQ_QUEUE_DEPTH = 16;

	localparam int OP_W       = 2;
	localparam int TYPE_W     = 31;
	localparam int LEN_W      = 16;
	localparam int HANDLE_W   = 32;
	localparam int FILTER_W   = 32;
	localparam int RSIZE_W    = 17;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 5;
	localparam int BYTES_W    = 20;

	typedef enum logic [OP_W-1:0] {
		OP_SEND  = 2'd0,
		OP_RECV  = 2'd1,
		OP_CLEAR = 2'd2
	} tmq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_TOO_BIG = 3'd2,
		ST_NO_MSG  = 3'd3,
		ST_WAIT    = 3'd4,
		ST_FULL    = 3'd5
	} tmq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_EVAL,
		S_SHIFT,
		S_DONE
	} tmq_state_t;

	// Filter zero takes any type, a positive filter an equal type, a negative
	// filter any type up to its magnitude; the except flag inverts the answer.
	function automatic logic type_hit(input logic [TYPE_W-1:0] t,
					  input logic signed [FILTER_W-1:0] f,
					  input logic exc);
		logic [FILTER_W-1:0] mag;
		logic                hit;
		mag = -f;
		hit = (f == '0) || ({1'b0, t} == f) || (f[FILTER_W-1] && ({1'b0, t} <= mag));
		return hit ^ exc;
	endfunction

endpackage

// ===== rtl/core/typed_message_queue_core.sv =====
// Typed message queue: ordered mailbox with selective receive, top level.
//
// Words enter on the req channel and each one gives exactly one word on the
// rsp channel. A send, a clear or a rejected request goes from the decode
// state straight to the done state. A receive runs a sequencer around one
// type compare unit and one single-port-read memory: after the decode state
// it checks one queued entry per cycle from the oldest, or in copy mode reads
// the entry that the filter names and leaves it queued, then evaluates the
// match; removing the entry moves each younger entry one place toward the
// head through the memory's read and write ports. The queue stops taking
// requests from acceptance until its result sits in the output register;
// the output register lets a new request enter while the last result still
// waits to be taken.
module typed_message_queue_core #(
	parameter int QUEUE_DEPTH = tmq_pkg::TMQ_QUEUE_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [tmq_pkg::OP_W-1:0]             op,
	input  logic [tmq_pkg::TYPE_W-1:0]           msg_type,
	input  logic [tmq_pkg::LEN_W-1:0]            msg_length,
	input  logic [tmq_pkg::HANDLE_W-1:0]         payload_handle,
	input  logic signed [tmq_pkg::FILTER_W-1:0]  type_filter,
	input  logic signed [tmq_pkg::RSIZE_W-1:0]   receive_size,
	input  logic                                 no_wait,
	input  logic                                 no_error,
	input  logic                                 copy_mode,
	input  logic                                 except_mode,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [tmq_pkg::STATUS_W-1:0]         status,
	output logic [tmq_pkg::TYPE_W-1:0]           got_type,
	output logic [tmq_pkg::LEN_W-1:0]            delivered_length,
	output logic [tmq_pkg::HANDLE_W-1:0]         got_handle,
	output logic [tmq_pkg::COUNT_W-1:0]          queued_count,
	output logic [tmq_pkg::BYTES_W-1:0]          queued_bytes
);
	import tmq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	tmq_state_t state_q, state_d;

	// Captured request.
	logic [OP_W-1:0]            op_q;
	logic [TYPE_W-1:0]          msg_type_q;
	logic [LEN_W-1:0]           msg_length_q;
	logic [HANDLE_W-1:0]        handle_q;
	logic signed [FILTER_W-1:0] filter_q;
	logic signed [RSIZE_W-1:0]  rsize_q;
	logic                       no_wait_q;
	logic                       no_error_q;
	logic                       copy_q;
	logic                       except_q;

	// Queue state.
	logic [CW-1:0]      count_q;
	logic [BYTES_W-1:0] bytes_q;

	logic [TYPE_W-1:0]   mem_type   [QUEUE_DEPTH];
	logic [LEN_W-1:0]    mem_len    [QUEUE_DEPTH];
	logic [HANDLE_W-1:0] mem_handle [QUEUE_DEPTH];

	logic [TYPE_W-1:0]   rd_type_q;
	logic [LEN_W-1:0]    rd_len_q;
	logic [HANDLE_W-1:0] rd_handle_q;
	logic [CW-1:0]       rd_idx_q;

	logic [CW-1:0] sh_rd_q;
	logic [CW-1:0] sh_wr_q;
	logic          sh_live_q;

	tmq_status_t         res_status_q;
	logic [TYPE_W-1:0]   res_type_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [HANDLE_W-1:0] res_handle_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [TYPE_W-1:0]   rsp_type_q;
	logic [LEN_W-1:0]    rsp_len_q;
	logic [HANDLE_W-1:0] rsp_handle_q;
	logic [COUNT_W-1:0]  rsp_count_q;
	logic [BYTES_W-1:0]  rsp_bytes_q;

	// Memory port controls.
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [TYPE_W-1:0]   mem_wtype;
	logic [LEN_W-1:0]    mem_wlen;
	logic [HANDLE_W-1:0] mem_whandle;

	// Conditions shared by the sequencer and the datapath.
	logic          req_take;
	logic          send_ok;
	logic          queue_full;
	logic          recv_bad;
	logic          copy_hit;
	logic          scan_hit;
	logic          scan_more;
	logic [CW-1:0] rd_nxt;
	logic          too_big;
	logic          shift_rd;
	logic          shift_end;
	logic          rsp_load;
	tmq_status_t   miss_status;

	always_comb begin
		req_take    = req_valid && !req_stall;
		send_ok     = (msg_type_q != '0) && (msg_length_q != '0);
		queue_full  = count_q >= DEPTH_C;
		recv_bad    = rsize_q[RSIZE_W-1] || (copy_q && (!no_wait_q || except_q));
		copy_hit    = !filter_q[FILTER_W-1] &&
			      (filter_q[FILTER_W-2:0] < (FILTER_W-1)'(count_q));
		scan_hit    = type_hit(rd_type_q, filter_q, except_q);
		rd_nxt      = rd_idx_q + CW'(1);
		scan_more   = rd_nxt < count_q;
		too_big     = rd_len_q > rsize_q[LEN_W-1:0];
		shift_rd    = sh_rd_q < count_q;
		shift_end   = !shift_rd && !sh_live_q;
		rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
		miss_status = no_wait_q ? ST_NO_MSG : ST_WAIT;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (op_q == OP_RECV && !recv_bad) begin
					if (copy_q) begin
						state_d = copy_hit ? S_EVAL : S_DONE;
					end else begin
						state_d = (count_q != '0) ? S_SCAN : S_DONE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_EVAL;
				end else if (!scan_more) begin
					state_d = S_DONE;
				end
			end
			S_EVAL: begin
				if ((too_big && !no_error_q) || copy_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (shift_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		req_stall   = (state_q != S_IDLE);
		mem_re      = 1'b0;
		mem_raddr   = '0;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wtype   = rd_type_q;
		mem_wlen    = rd_len_q;
		mem_whandle = rd_handle_q;
		case (state_q)
			S_DECODE: begin
				if (op_q == OP_SEND && send_ok && !queue_full) begin
					mem_we      = 1'b1;
					mem_waddr   = count_q[AW-1:0];
					mem_wtype   = msg_type_q;
					mem_wlen    = msg_length_q;
					mem_whandle = handle_q;
				end
				if (op_q == OP_RECV && !recv_bad) begin
					mem_re    = 1'b1;
					mem_raddr = copy_q ? filter_q[AW-1:0] : '0;
				end
			end
			S_SCAN: begin
				mem_re    = !scan_hit && scan_more;
				mem_raddr = rd_nxt[AW-1:0];
			end
			S_SHIFT: begin
				// Read the next younger entry while the one read last cycle
				// lands one place closer to the head.
				mem_re    = shift_rd;
				mem_raddr = sh_rd_q[AW-1:0];
				mem_we    = sh_live_q;
				mem_waddr = sh_wr_q[AW-1:0];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			bytes_q     <= '0;
			sh_live_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: begin
					if (op_q == OP_SEND && send_ok && !queue_full) begin
						count_q <= count_q + CW'(1);
						bytes_q <= bytes_q + BYTES_W'(msg_length_q);
					end else if (op_q == OP_CLEAR) begin
						count_q <= '0;
						bytes_q <= '0;
					end
				end
				S_EVAL: begin
					sh_live_q <= 1'b0;
					if (!(too_big && !no_error_q) && !copy_q) begin
						bytes_q <= bytes_q - BYTES_W'(rd_len_q);
					end
				end
				S_SHIFT: begin
					sh_live_q <= shift_rd;
					if (shift_end) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					sh_live_q <= sh_live_q;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Entry memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_type[mem_waddr]   <= mem_wtype;
			mem_len[mem_waddr]    <= mem_wlen;
			mem_handle[mem_waddr] <= mem_whandle;
		end
		if (mem_re) begin
			rd_type_q   <= mem_type[mem_raddr];
			rd_len_q    <= mem_len[mem_raddr];
			rd_handle_q <= mem_handle[mem_raddr];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q         <= op;
			msg_type_q   <= msg_type;
			msg_length_q <= msg_length;
			handle_q     <= payload_handle;
			filter_q     <= type_filter;
			rsize_q      <= receive_size;
			no_wait_q    <= no_wait;
			no_error_q   <= no_error;
			copy_q       <= copy_mode;
			except_q     <= except_mode;
		end
		case (state_q)
			S_DECODE: begin
				res_type_q   <= '0;
				res_len_q    <= '0;
				res_handle_q <= '0;
				rd_idx_q     <= copy_q ? filter_q[CW-1:0] : '0;
				case (op_q)
					OP_SEND: begin
						if (!send_ok) begin
							res_status_q <= ST_INVALID;
						end else if (queue_full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_OK;
						end
					end
					OP_RECV: begin
						if (recv_bad) begin
							res_status_q <= ST_INVALID;
						end else if (copy_q ? !copy_hit : (count_q == '0)) begin
							res_status_q <= miss_status;
						end else begin
							res_status_q <= ST_OK;
						end
					end
					OP_CLEAR: res_status_q <= ST_OK;
					default:  res_status_q <= ST_INVALID;
				endcase
			end
			S_SCAN: begin
				if (!scan_hit) begin
					if (scan_more) begin
						rd_idx_q <= rd_nxt;
					end else begin
						res_status_q <= miss_status;
					end
				end
			end
			S_EVAL: begin
				sh_rd_q <= rd_idx_q + CW'(1);
				sh_wr_q <= rd_idx_q;
				if (too_big && !no_error_q) begin
					res_status_q <= ST_TOO_BIG;
				end else begin
					res_type_q   <= rd_type_q;
					res_len_q    <= too_big ? rsize_q[LEN_W-1:0] : rd_len_q;
					res_handle_q <= rd_handle_q;
				end
			end
			S_SHIFT: begin
				if (sh_live_q) begin
					sh_wr_q <= sh_wr_q + CW'(1);
				end
				if (shift_rd) begin
					sh_rd_q <= sh_rd_q + CW'(1);
				end
			end
			default: begin
				rd_idx_q <= rd_idx_q;
			end
		endcase
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_type_q   <= res_type_q;
			rsp_len_q    <= res_len_q;
			rsp_handle_q <= res_handle_q;
			rsp_count_q  <= COUNT_W'(count_q);
			rsp_bytes_q  <= bytes_q;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign status           = rsp_status_q;
	assign got_type         = rsp_type_q;
	assign delivered_length = rsp_len_q;
	assign got_handle       = rsp_handle_q;
	assign queued_count     = rsp_count_q;
	assign queued_bytes     = rsp_bytes_q;

endmodule

// ===== rtl/core/tmq_checker.sv =====
// Port-level checker of the typed message queue, bound to the top level.
`include "typed_message_queue_core_assert.svh"

module tmq_checker #(
	parameter int QUEUE_DEPTH = tmq_pkg::TMQ_QUEUE_DEPTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [tmq_pkg::STATUS_W-1:0]  status,
	input logic [tmq_pkg::TYPE_W-1:0]    got_type,
	input logic [tmq_pkg::LEN_W-1:0]     delivered_length,
	input logic [tmq_pkg::HANDLE_W-1:0]  got_handle,
	input logic [tmq_pkg::COUNT_W-1:0]   queued_count,
	input logic [tmq_pkg::BYTES_W-1:0]   queued_bytes
);
	import tmq_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

	`TMQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(got_handle) && $stable(queued_count), "rsp word changed while stalled")
	`TMQ_ASSERT_NOW(a_fail_zero, rsp_valid && (status != ST_OK), (got_type == '0) && (delivered_length == '0) && (got_handle == '0), "failed result carries a message")
	`TMQ_ASSERT_NOW(a_full_count, rsp_valid && (status == ST_FULL), queued_count == FULL_COUNT, "full status with a queue that is not full")
	`TMQ_ASSERT_NOW(a_empty_bytes, rsp_valid && (QUEUE_DEPTH < 32) && (queued_count == '0), queued_bytes == '0, "empty queue reports queued bytes")

endmodule

bind typed_message_queue_core tmq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tmq_checker (.*);
